// File: rtl/bcc_pkg.sv
package bcc_pkg;

  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned CfgIdxWidth = 8;

  localparam logic [CfgWidth-1:0] DebounceReset   = 16'd30;
  localparam logic [CfgWidth-1:0] ShortLimitReset = 16'd800;
  localparam logic [CfgWidth-1:0] LongTimeReset   = 16'd15000;
  localparam logic [CfgWidth-1:0] WindowReset     = 16'd600;

  localparam logic [CfgIdxWidth-1:0] RegDebounce   = 8'd0;
  localparam logic [CfgIdxWidth-1:0] RegShortLimit = 8'd1;
  localparam logic [CfgIdxWidth-1:0] RegLongTime   = 8'd2;
  localparam logic [CfgIdxWidth-1:0] RegWindow     = 8'd3;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_TRIPLE = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_time;
    logic [CfgWidth-1:0] short_press_limit;
    logic [CfgWidth-1:0] long_press_time;
    logic [CfgWidth-1:0] click_window;
  } cfg_t;

endpackage

// File: rtl/bcc_core.sv
module bcc_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [bcc_pkg::TimeWidth-1:0]   time_ms_i,
  input  logic                            level_i,
  input  bcc_pkg::cfg_t                   cfg_i,
  output bcc_pkg::event_e                 event_o
);
  import bcc_pkg::*;

  logic                  stable_q, stable_d;
  logic [TimeWidth-1:0]  edge_time_q, edge_time_d;
  logic [TimeWidth-1:0]  press_start_q, press_start_d;
  logic [TimeWidth-1:0]  release_time_q, release_time_d;
  logic [CountWidth-1:0] count_q, count_d;

  logic                  edge_ok;
  logic                  short_ok;
  logic                  long_hit;
  logic [CountWidth-1:0] count_n;
  logic                  stable_n;

  // Edge acceptance and press bookkeeping; the long-press test then looks at the
  // press start as it stands after this poll's edge.
  always_comb begin
    edge_ok = (level_i != stable_q) &&
              ((time_ms_i - edge_time_q) > {16'd0, cfg_i.debounce_time});
    stable_n      = edge_ok ? level_i : stable_q;
    edge_time_d   = edge_ok ? time_ms_i : edge_time_q;
    press_start_d = (edge_ok && !level_i) ? time_ms_i : press_start_q;
    short_ok = edge_ok && level_i &&
               ((time_ms_i - press_start_q) <= {16'd0, cfg_i.short_press_limit});
    count_n        = short_ok ? count_q + 8'd1 : count_q;
    release_time_d = short_ok ? time_ms_i : release_time_q;
    long_hit = !level_i &&
               ((time_ms_i - press_start_d) >= {16'd0, cfg_i.long_press_time});

    stable_d = stable_n;
    count_d  = count_n;
    event_o  = EV_NONE;
    if (long_hit) begin
      stable_d = 1'b1;
      count_d  = '0;
      event_o  = EV_LONG;
    end else if ((count_n != '0) &&
                 ((time_ms_i - release_time_d) > {16'd0, cfg_i.click_window})) begin
      case (count_n)
        8'd1:    event_o = EV_SINGLE;
        8'd3:    event_o = EV_TRIPLE;
        default: event_o = EV_NONE;
      endcase
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q       <= 1'b1;
      edge_time_q    <= '0;
      press_start_q  <= '0;
      release_time_q <= '0;
      count_q        <= '0;
    end else if (step_i) begin
      stable_q       <= stable_d;
      edge_time_q    <= edge_time_d;
      press_start_q  <= press_start_d;
      release_time_q <= release_time_d;
      count_q        <= count_d;
    end
  end

endmodule

// File: rtl/button_click_classifier_top.sv
// Button click classifier: one poll in, one event out.
// Path: each poll goes from the input transfer into the input register, then
// through the classification logic into the result register, which feeds the
// result transfer.
// Throughput: one poll per cycle; only output stall holds the pipeline back.
// Reset (async, active low) empties both registers, restores the default
// timing registers and returns the button state to released with no clicks.
module button_click_classifier_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bcc_pkg::TimeWidth-1:0]     time_ms_i,
  input  logic                              level_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        event_res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bcc_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  logic [bcc_pkg::CfgWidth-1:0]      cfg_data_i
);
  import bcc_pkg::*;

  cfg_t                 cfg_q;
  logic                 in_valid_q;
  logic [TimeWidth-1:0] in_time_q;
  logic                 in_level_q;
  logic                 out_valid_q;
  event_e               out_event_q;
  event_e               core_event;
  logic                 advance;
  logic                 step;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time     <= DebounceReset;
      cfg_q.short_press_limit <= ShortLimitReset;
      cfg_q.long_press_time   <= LongTimeReset;
      cfg_q.click_window      <= WindowReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegDebounce:   cfg_q.debounce_time     <= cfg_data_i;
        RegShortLimit: cfg_q.short_press_limit <= cfg_data_i;
        RegLongTime:   cfg_q.long_press_time   <= cfg_data_i;
        RegWindow:     cfg_q.click_window      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The result register frees up when it is empty or its transfer completes.
  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_time_q  <= time_ms_i;
      in_level_q <= level_i;
    end
  end

  bcc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .time_ms_i (in_time_q),
    .level_i   (in_level_q),
    .cfg_i     (cfg_q),
    .event_o   (core_event)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_event_q <= core_event;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = out_event_q;

  a_stall_only_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_step_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed poll did not reach the result register");

  a_long_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_level_q) |=> (out_event_q != EV_LONG))
    else $error("long press reported for a released poll");

endmodule
